### rtl/core/mdmw_pkg.sv
// Shared types and constants of the mecanum drive mixer with command watchdog.
// Used by mdmw_watchdog and the top level under rtl/core; depends on nothing else.
package mdmw_pkg;

  localparam int AXIS_W     = 16;
  localparam int TTL_W      = 16;
  localparam int MASK_W     = 4;
  localparam int DEADBAND_W = 15;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PINS_W     = 8;

  localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TTL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TTL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_MASK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 2'd3;

  localparam logic [TTL_W-1:0]      DEFAULT_TTL_RESET = 16'd300;
  localparam logic [TTL_W-1:0]      MAX_TTL_RESET     = 16'd1000;
  localparam logic [MASK_W-1:0]     REV_MASK_RESET    = 4'd10;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET    = 15'd16;

  typedef struct packed {
    logic             drive;
    logic             tick;
    logic             stop;
    logic             cmd_active;
    logic [TTL_W-1:0] ttl_request;
  } wdg_req_t;

endpackage

### rtl/core/mdmw_divider.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
// Depends on nothing; the numerator's upper part must be below the divisor.
module mdmw_divider #(
  parameter int DEN_W = 17,
  parameter int Q_W   = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DEN_W+Q_W-1:0] num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [Q_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(Q_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   shift_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_r, shift_r[Q_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        rem_r   <= num[DEN_W+Q_W-1:Q_W];
        shift_r <= num[Q_W-1:0];
        den_r   <= den;
      end else if (busy_r) begin
        rem_r   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        shift_r <= {shift_r[Q_W-2:0], fits};
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = shift_r;

endmodule

### rtl/core/mdmw_watchdog.sv
// Command lifetime, age counter and drive-active flag of the watchdog.
// Depends on mdmw_pkg for the request structure and reset constants.
module mdmw_watchdog #(
  parameter int AGE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mdmw_pkg::wdg_req_t        req,
  input  logic [mdmw_pkg::TTL_W-1:0] default_ttl,
  input  logic [mdmw_pkg::TTL_W-1:0] max_ttl,
  output logic                      expire
);
  import mdmw_pkg::*;

  localparam int CW = (AGE_BITS > TTL_W) ? AGE_BITS : TTL_W;

  logic                active_r;
  logic [AGE_BITS-1:0] age_r;
  logic [TTL_W-1:0]    ttl_r;
  logic [AGE_BITS-1:0] age_inc;
  logic [TTL_W-1:0]    limit;
  logic [TTL_W-1:0]    ttl_sel;
  logic [TTL_W-1:0]    ttl_cap;

  always_comb begin
    age_inc = (age_r == '1) ? age_r : age_r + 1'b1;
    limit   = (ttl_r == '0) ? default_ttl : ttl_r;
    expire  = req.tick && active_r && (CW'(age_inc) > CW'(limit));
    ttl_sel = (req.ttl_request == '0) ? default_ttl : req.ttl_request;
    ttl_cap = (ttl_sel > max_ttl) ? max_ttl : ttl_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      age_r    <= '0;
      ttl_r    <= DEFAULT_TTL_RESET;
    end else if (req.drive) begin
      active_r <= req.cmd_active;
      age_r    <= '0;
      ttl_r    <= ttl_cap;
    end else if (req.tick) begin
      age_r <= age_inc;
      if (expire) begin
        active_r <= 1'b0;
      end
    end else if (req.stop) begin
      active_r <= 1'b0;
      age_r    <= '0;
      ttl_r    <= default_ttl;
    end
  end

endmodule

### rtl/core/mecanum_drive_mixer_watchdog.sv
// Mecanum drive mixer with command watchdog: top level, sequencer and registers.
// A drive command passes through S_DECODE and S_MAX, then S_PREP and S_DIV once per wheel
// on the bit-serial divider, and then S_DONE before the next transaction is taken.
// Ticks and stops pass through S_DECODE and S_DONE; a tick that does not expire gives no
// result; the next may be taken while a result waits at the output.
// Synchronous active-low reset restores register defaults and clears the watchdog.
module mecanum_drive_mixer_watchdog #(
  parameter int PWM_BITS       = 10,
  parameter int AXIS_FRAC_BITS = 14,
  parameter int AGE_BITS       = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mdmw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdmw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mdmw_pkg::MODE_W-1:0]     in_mode,
  input  logic signed [mdmw_pkg::AXIS_W-1:0] in_x_in,
  input  logic signed [mdmw_pkg::AXIS_W-1:0] in_y_in,
  input  logic signed [mdmw_pkg::AXIS_W-1:0] in_r_in,
  input  logic [mdmw_pkg::TTL_W-1:0]      in_ttl_request,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [PWM_BITS-1:0]             out_duty_fl,
  output logic [PWM_BITS-1:0]             out_duty_fr,
  output logic [PWM_BITS-1:0]             out_duty_bl,
  output logic [PWM_BITS-1:0]             out_duty_br,
  output logic [mdmw_pkg::PINS_W-1:0]     out_bridge_pins,
  output logic                            out_active,
  output logic                            out_expired
);
  import mdmw_pkg::*;

  localparam int F      = AXIS_FRAC_BITS;
  localparam int P      = PWM_BITS;
  localparam int SW     = F + 3;
  localparam int MAG_W  = F + 2;
  localparam int EXT_W  = (F + 2 > AXIS_W) ? F + 2 : AXIS_W;
  localparam int CMP_W  = (MAG_W > DEADBAND_W) ? MAG_W : DEADBAND_W;
  localparam int DEN_W  = MAG_W + 1;
  localparam int NUM_W  = DEN_W + P;

  localparam logic signed [EXT_W-1:0] ONE_EXT     = EXT_W'(1) <<< F;
  localparam logic signed [EXT_W-1:0] NEG_ONE_EXT = -ONE_EXT;
  localparam logic [MAG_W-1:0]        ONE_MAG     = MAG_W'(1) << F;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MAX, S_PREP, S_DIV, S_DONE
  } state_t;

  function automatic logic signed [SW-1:0] clamp_axis(input logic signed [AXIS_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    logic signed [EXT_W-1:0] c;
    e = EXT_W'(v);
    if (e > ONE_EXT) begin
      c = ONE_EXT;
    end else if (e < NEG_ONE_EXT) begin
      c = NEG_ONE_EXT;
    end else begin
      c = e;
    end
    return SW'(c);
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] n;
    n = v[SW-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  state_t state_r;

  logic [TTL_W-1:0]      default_ttl_r;
  logic [TTL_W-1:0]      max_ttl_r;
  logic [MASK_W-1:0]     rev_mask_r;
  logic [DEADBAND_W-1:0] deadband_r;

  logic [MODE_W-1:0]        mode_r;
  logic signed [AXIS_W-1:0] x_r;
  logic signed [AXIS_W-1:0] y_r;
  logic signed [AXIS_W-1:0] r_r;
  logic [TTL_W-1:0]         ttl_req_r;

  logic [MAG_W-1:0] mag_sr_r [4];
  logic             sign_sr_r [4];
  logic [P-1:0]     duty_sr_r [4];
  logic [PINS_W-1:0] pins_r;
  logic [MAG_W-1:0] denom_r;
  logic [1:0]       wheel_r;
  logic             res_active_r;
  logic             res_expired_r;

  logic             out_valid_r;
  logic [P-1:0]     out_duty_r [4];
  logic [PINS_W-1:0] out_pins_r;
  logic             out_active_r;
  logic             out_expired_r;

  logic signed [SW-1:0] xc;
  logic signed [SW-1:0] yc;
  logic signed [SW-1:0] rc;
  logic signed [SW-1:0] wheel [4];
  logic                 cmd_active;
  logic [MAG_W-1:0]     max01;
  logic [MAG_W-1:0]     max23;
  logic [MAG_W-1:0]     max_all;
  logic [NUM_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_den;
  logic                 div_start;
  logic                 div_done;
  logic [P-1:0]         div_q;
  logic                 pin_a;
  logic                 out_free;
  wdg_req_t             wdg_req;
  logic                 wdg_expire;

  always_comb begin
    xc = clamp_axis(x_r);
    yc = clamp_axis(y_r);
    rc = clamp_axis(r_r);
    wheel[0] = yc + xc - rc;
    wheel[1] = yc - xc + rc;
    wheel[2] = yc - xc - rc;
    wheel[3] = yc + xc + rc;
    cmd_active = (CMP_W'(mag_of(xc)) > CMP_W'(deadband_r)) ||
                 (CMP_W'(mag_of(yc)) > CMP_W'(deadband_r)) ||
                 (CMP_W'(mag_of(rc)) > CMP_W'(deadband_r));

    max01   = (mag_sr_r[0] > mag_sr_r[1]) ? mag_sr_r[0] : mag_sr_r[1];
    max23   = (mag_sr_r[2] > mag_sr_r[3]) ? mag_sr_r[2] : mag_sr_r[3];
    max_all = (max01 > max23) ? max01 : max23;

    div_num = (NUM_W'(mag_sr_r[0]) << (P + 1)) - (NUM_W'(mag_sr_r[0]) << 1)
              + NUM_W'(denom_r);
    div_den   = {denom_r, 1'b0};
    div_start = (state_r == S_PREP);

    pin_a    = (!sign_sr_r[0]) != rev_mask_r[wheel_r];
    out_free = !out_valid_r || out_ready;

    wdg_req.drive       = (state_r == S_DECODE) && (mode_r == MODE_DRIVE);
    wdg_req.tick        = (state_r == S_DECODE) && (mode_r == MODE_TICK);
    wdg_req.stop        = (state_r == S_DECODE) && (mode_r == MODE_STOP);
    wdg_req.cmd_active  = cmd_active;
    wdg_req.ttl_request = ttl_req_r;
  end

  mdmw_divider #(
    .DEN_W (DEN_W),
    .Q_W   (P)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  mdmw_watchdog #(
    .AGE_BITS (AGE_BITS)
  ) u_watchdog (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (wdg_req),
    .default_ttl (default_ttl_r),
    .max_ttl     (max_ttl_r),
    .expire      (wdg_expire)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      default_ttl_r <= DEFAULT_TTL_RESET;
      max_ttl_r     <= MAX_TTL_RESET;
      rev_mask_r    <= REV_MASK_RESET;
      deadband_r    <= DEADBAND_RESET;
      wheel_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEFAULT_TTL: default_ttl_r <= cfg_data[TTL_W-1:0];
          CFG_MAX_TTL:     max_ttl_r     <= cfg_data[TTL_W-1:0];
          CFG_REV_MASK:    rev_mask_r    <= cfg_data[MASK_W-1:0];
          CFG_DEADBAND:    deadband_r    <= cfg_data[DEADBAND_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r    <= in_mode;
            x_r       <= in_x_in;
            y_r       <= in_y_in;
            r_r       <= in_r_in;
            ttl_req_r <= in_ttl_request;
            state_r   <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_active_r  <= 1'b0;
          res_expired_r <= 1'b0;
          pins_r        <= '0;
          for (int i = 0; i < 4; i++) begin
            duty_sr_r[i] <= '0;
          end
          case (mode_r)
            MODE_DRIVE: begin
              for (int i = 0; i < 4; i++) begin
                mag_sr_r[i]  <= mag_of(wheel[i]);
                sign_sr_r[i] <= wheel[i][SW-1];
              end
              res_active_r <= cmd_active;
              state_r      <= S_MAX;
            end
            MODE_TICK: begin
              res_expired_r <= 1'b1;
              state_r       <= wdg_expire ? S_DONE : S_IDLE;
            end
            MODE_STOP: begin
              state_r <= S_DONE;
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end
        S_MAX: begin
          denom_r <= (max_all > ONE_MAG) ? max_all : ONE_MAG;
          wheel_r <= '0;
          state_r <= S_PREP;
        end
        S_PREP: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            duty_sr_r[3] <= div_q;
            for (int i = 0; i < 3; i++) begin
              duty_sr_r[i]  <= duty_sr_r[i+1];
              mag_sr_r[i]   <= mag_sr_r[i+1];
              sign_sr_r[i]  <= sign_sr_r[i+1];
            end
            pins_r  <= {((div_q != '0) ? {!pin_a, pin_a} : 2'b00), pins_r[PINS_W-1:2]};
            wheel_r <= wheel_r + 1'b1;
            state_r <= (wheel_r == 2'd3) ? S_DONE : S_PREP;
          end
        end
        S_DONE: begin
          if (out_free) begin
            for (int i = 0; i < 4; i++) begin
              out_duty_r[i] <= duty_sr_r[i];
            end
            out_pins_r    <= pins_r;
            out_active_r  <= res_active_r;
            out_expired_r <= res_expired_r;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_duty_fl     = out_duty_r[0];
  assign out_duty_fr     = out_duty_r[1];
  assign out_duty_bl     = out_duty_r[2];
  assign out_duty_br     = out_duty_r[3];
  assign out_bridge_pins = out_pins_r;
  assign out_active      = out_active_r;
  assign out_expired     = out_expired_r;

  a_expire_reaches_output : assert property (@(posedge clk) disable iff (!rst_n)
    wdg_expire |=> (state_r == S_DONE))
    else $error("watchdog expiry did not lead to a result");

  a_expired_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_expired) |-> (!out_active && (out_bridge_pins == '0) &&
      (out_duty_fl == '0) && (out_duty_fr == '0) && (out_duty_bl == '0) &&
      (out_duty_br == '0)))
    else $error("expiry transaction carries drive levels");

  a_pins_not_shorted : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_bridge_pins & (out_bridge_pins >> 1) & 8'h55) == 8'h00))
    else $error("both bridge pins of a wheel driven high");

  a_no_accept_while_dividing : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !in_ready)
    else $error("divider finished while the sequencer was idle");

endmodule
